### rtl/deque_with_value_removal_core_macros.svh
// Assertion macros for the deque with value removal.
// Used by the checker module; depends on nothing else.
`ifndef DEQUE_WITH_VALUE_REMOVAL_CORE_MACROS_SVH
`define DEQUE_WITH_VALUE_REMOVAL_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DQVR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DQVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

### rtl/dqvr_pkg.sv
// Shared types and codes for the deque with value removal.
// Used by the core and its checker; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dqvr_pkg;

    typedef logic [2:0]        opcode_t;
    typedef logic [1:0]        status_t;
    typedef logic signed [31:0] value_t;
    typedef logic [4:0]        count_out_t;

    // Operation codes.
    localparam opcode_t OP_PUSH_BACK  = 3'd0;
    localparam opcode_t OP_PUSH_FRONT = 3'd1;
    localparam opcode_t OP_POP_BACK   = 3'd2;
    localparam opcode_t OP_POP_FRONT  = 3'd3;
    localparam opcode_t OP_REMOVE     = 3'd4;

    // Result status codes.
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_EMPTY    = 2'd1;
    localparam status_t ST_NOTFOUND = 2'd2;
    localparam status_t ST_FULL     = 2'd3;

endpackage

`default_nettype wire

### rtl/deque_with_value_removal_core.sv
// A push, no-op, or pop or remove on an empty list goes from S_EXEC to S_DONE; other pops
// pass S_POP_RD to read the entry. Remove compares entries from the front (S_SCAN_RD,
// S_SCAN_CMP), then moves the entries after the match down (S_SHIFT_RD, S_SHIFT_WR). One
// memory port pair and one compare unit set this; s_ready is low from acceptance until
// the result is registered, so the next beat can be accepted once m_valid rises, later
// while an old result still waits. Reset (aresetn low, synchronous) empties the list and
// clears strict mode; the entry memory itself is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module deque_with_value_removal_core #(
    parameter int DEPTH = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input beats.
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire dqvr_pkg::opcode_t    s_opcode,
    input  wire dqvr_pkg::value_t     s_data_in,
    // Result beats.
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output dqvr_pkg::value_t          m_data_out,
    output dqvr_pkg::status_t         m_status,
    output dqvr_pkg::count_out_t      m_entry_count,
    // Configuration beats.
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_strict_mode
);
    import dqvr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    // Sequencer states.
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_POP_RD   = 3'd2;
    localparam logic [2:0] S_SCAN_RD  = 3'd3;
    localparam logic [2:0] S_SCAN_CMP = 3'd4;
    localparam logic [2:0] S_SHIFT_RD = 3'd5;
    localparam logic [2:0] S_SHIFT_WR = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    opcode_t       op_reg;
    value_t        data_reg;
    logic          strict_reg;
    value_t        dout_reg, dout_next;
    status_t       status_reg, status_next;
    logic          m_valid_reg;
    value_t        m_data_out_reg;
    status_t       m_status_reg;
    count_out_t    m_count_reg;

    // Entry memory with registered read data.
    logic [31:0]   mem [DEPTH];
    logic [31:0]   rd_data_reg;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [31:0]   wr_data;

    // Shared address unit: list position to circular memory address.
    logic [CW-1:0] pos_off;
    logic [SW-1:0] pos_sum;
    logic [AW-1:0] pos_addr;
    logic [AW-1:0] head_dec;
    logic          is_full, is_empty, match, load_out;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_data_out    = m_data_out_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_count_reg;

    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign match    = (rd_data_reg == data_reg);
    assign load_out = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : (head_reg - AW'(1));

    // Select the list offset that the address unit converts this cycle.
    always_comb begin
        pos_off = idx_reg;
        if (state_reg == S_EXEC) begin
            if (op_reg == OP_PUSH_BACK) begin
                pos_off = count_reg;
            end else if (op_reg == OP_POP_BACK) begin
                pos_off = count_reg - CW'(1);
            end else begin
                pos_off = '0;
            end
        end else if (state_reg == S_SHIFT_RD) begin
            pos_off = idx_reg + CW'(1);
        end
    end

    // Wrap head plus offset once; the sum stays below twice the depth.
    assign pos_sum  = SW'(head_reg) + SW'(pos_off);
    assign pos_addr = (pos_sum >= SW'(DEPTH)) ? AW'(pos_sum - SW'(DEPTH)) : AW'(pos_sum);

    // Sequencer: one memory access and one compare per step.
    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        dout_next   = dout_reg;
        status_next = status_reg;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        rd_addr     = pos_addr;
        wr_addr     = pos_addr;
        wr_data     = data_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                dout_next   = '0;
                status_next = ST_OK;
                state_next  = S_DONE;
                unique case (op_reg)
                    OP_PUSH_BACK: begin
                        if (is_full) begin
                            status_next = ST_FULL;
                        end else begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_PUSH_FRONT: begin
                        if (is_full) begin
                            status_next = ST_FULL;
                        end else begin
                            wr_en      = 1'b1;
                            wr_addr    = head_dec;
                            head_next  = head_dec;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_POP_BACK, OP_POP_FRONT: begin
                        if (is_empty) begin
                            status_next = ST_EMPTY;
                        end else begin
                            rd_en      = 1'b1;
                            count_next = count_reg - CW'(1);
                            state_next = S_POP_RD;
                            if (op_reg == OP_POP_FRONT) begin
                                head_next = (head_reg == AW'(DEPTH - 1)) ? '0
                                                                          : head_reg + AW'(1);
                            end
                        end
                    end
                    OP_REMOVE: begin
                        if (is_empty) begin
                            status_next = strict_reg ? ST_EMPTY : ST_OK;
                        end else begin
                            idx_next   = '0;
                            state_next = S_SCAN_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_POP_RD: begin
                dout_next  = rd_data_reg;
                state_next = S_DONE;
            end
            S_SCAN_RD: begin
                rd_en      = 1'b1;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (match) begin
                    if ((idx_reg + CW'(1)) == count_reg) begin
                        count_next = count_reg - CW'(1);
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SHIFT_RD;
                    end
                end else if ((idx_reg + CW'(1)) == count_reg) begin
                    status_next = strict_reg ? ST_NOTFOUND : ST_OK;
                    state_next  = S_DONE;
                end else begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                rd_en      = 1'b1;
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                wr_en   = 1'b1;
                wr_data = rd_data_reg;
                if ((idx_reg + CW'(2)) == count_reg) begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end else begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_SHIFT_RD;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Entry memory.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            strict_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cfg_valid) begin
                strict_reg <= cfg_strict_mode;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        dout_reg   <= dout_next;
        status_reg <= status_next;
        if (s_valid && s_ready) begin
            op_reg   <= s_opcode;
            data_reg <= s_data_in;
        end
        if (load_out) begin
            m_data_out_reg <= dout_reg;
            m_status_reg   <= status_reg;
            m_count_reg    <= count_out_t'(count_reg);
        end
    end

endmodule

`default_nettype wire

### rtl/dqvr_checker.sv
// Port-level checker for the deque with value removal, bound to the core.
// Depends on dqvr_pkg and deque_with_value_removal_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "deque_with_value_removal_core_macros.svh"

module dqvr_checker #(
    parameter int DEPTH = 16
) (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire dqvr_pkg::value_t     m_data_out,
    input wire dqvr_pkg::status_t    m_status,
    input wire dqvr_pkg::count_out_t m_entry_count
);
    import dqvr_pkg::*;

    // A stalled result beat holds its payload.
    `DQVR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data_out) && $stable(m_status) && $stable(m_entry_count))

    // The block works on one item at a time.
    `DQVR_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // Every error result carries a zero value.
    `DQVR_ASSERT_SAME(a_error_zero, aclk, aresetn, m_valid && (m_status != ST_OK), m_data_out == '0)

    // A full report comes with a full count, an empty report with none.
    `DQVR_ASSERT_SAME(a_full_count, aclk, aresetn, m_valid && (m_status == ST_FULL), m_entry_count == count_out_t'(DEPTH))
    `DQVR_ASSERT_SAME(a_empty_count, aclk, aresetn, m_valid && (m_status == ST_EMPTY), m_entry_count == '0)

endmodule

bind deque_with_value_removal_core dqvr_checker #(.DEPTH(DEPTH)) u_dqvr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_data_out    (m_data_out),
    .m_status      (m_status),
    .m_entry_count (m_entry_count)
);

`default_nettype wire
